@@ hw/rtl/vram_upload_rle_writer_core_assert.svh @@
// Assertion macros for the upload RLE writer checker
`ifndef VRAM_UPLOAD_RLE_WRITER_CORE_ASSERT_SVH
`define VRAM_UPLOAD_RLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define VURW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vurw assertion failed");

// Next-cycle implication, disabled while reset is high
`define VURW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vurw assertion failed");

`endif

@@ hw/rtl/vurw_pkg.sv @@
// Types and constants of the VRAM upload RLE writer
package vurw_pkg;

   localparam int VRAM_ADDR_BITS = 17;
   localparam int LEN_BITS       = 16;
   localparam int SIZE_BITS      = 18;

   localparam logic [LEN_BITS-1:0] HDR_BYTES     = LEN_BITS'(9);
   localparam logic [7:0]          LITERAL_TOKEN = 8'h00;

   // CSR map: one 32-bit register per word
   localparam int         CSR_ADDR_BITS  = 3;
   localparam logic [0:0] CSR_IDX_SIZE   = 1'b0;
   localparam logic [0:0] CSR_IDX_READY  = 1'b1;

   // Request tdata: data_byte, payload_len
   localparam int REQ_FIELD_W = 8 + LEN_BITS;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_RAW     = 3'd1,
      PH_TOKEN   = 3'd2,
      PH_VALUE   = 3'd3,
      PH_LITLEN  = 3'd4,
      PH_LITERAL = 3'd5,
      PH_IGNORE  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Result fields, last field in the lowest bits
   typedef struct packed {
      logic [SIZE_BITS-1:0]      free_bytes;
      logic [SIZE_BITS-1:0]      used_bytes;
      status_type                status;
      logic [7:0]                write_repeat;
      logic [7:0]                write_value;
      logic [VRAM_ADDR_BITS-1:0] write_address;
      logic                      write_valid;
   } rsp_fields_type;

   typedef struct packed {
      logic           last;
      rsp_fields_type fields;
   } rsp_item_type;

   localparam int RSP_FIELD_W    = $bits(rsp_fields_type);
   localparam int RSP_DATA_W     = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_VALUE_LSB  = VRAM_ADDR_BITS + 1;
   localparam int RSP_REPEAT_LSB = VRAM_ADDR_BITS + 9;
   localparam int RSP_STATUS_LSB = VRAM_ADDR_BITS + 17;

endpackage

@@ hw/rtl/vram_upload_rle_writer_core.sv @@
// VRAM upload writer: header parse, raw copy and RLE decode into write bursts
//
// Takes an upload packet one byte per req transfer (payload_len rides along
// with every byte) and returns exactly one rsp transfer per byte. The first
// nine bytes form the header: offset (LE32), count (LE32) and a mode byte
// (nonzero = RLE). After it, each byte yields at most one burst descriptor
// (address, value, repeat), clipped to count bytes. In RLE a nonzero token
// repeats the next byte; a zero token is followed by a length n and n
// literal bytes. The packet's last byte carries tlast and the status
// (ok / invalid parameter / VRAM full) plus the high-water mark and the free
// space. Throughput is one byte per cycle while req_tready is high: decode is
// combinational logic from the packet state registers into the result register,
// and a two-entry result buffer (result register plus skid entry) keeps
// req_tready high while one result waits. The user must write vram_size and
// vram_ready via the CSR port only while idle; the block does not enforce it.
module vram_upload_rle_writer_core import vurw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // Byte stream in
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_W-1:0]    req_tdata,   // data_byte, payload_len
   // Burst descriptors and status out
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata,   // write_valid, write_address,
                                                 // write_value, write_repeat,
                                                 // status, used_bytes,
                                                 // free_bytes
   output logic                     rsp_tlast,   // done_res
   // CSR port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   // ---------------- configuration registers ----------------
   logic [SIZE_BITS-1:0] vram_size_ff;
   logic                 vram_ready_ff;
   logic                 csr_wr;
   logic [0:0]           csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vram_size_ff  <= '0;
         vram_ready_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_SIZE:  vram_size_ff  <= csr_pwdata[SIZE_BITS-1:0];
            CSR_IDX_READY: vram_ready_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_SIZE:  csr_prdata = 32'(vram_size_ff);
         CSR_IDX_READY: csr_prdata = 32'(vram_ready_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- packet state ----------------
   logic [LEN_BITS-1:0]  byte_index_ff,    byte_index_in;
   logic [31:0]          hdr_offset_ff,    hdr_offset_in;
   logic [31:0]          hdr_count_ff,     hdr_count_in;
   logic                 rle_mode_ff,      rle_mode_in;
   phase_type            phase_ff,         phase_in;
   logic [7:0]           run_token_ff,     run_token_in;
   logic [7:0]           literal_left_ff,  literal_left_in;
   logic [SIZE_BITS-1:0] dest_pos_ff,      dest_pos_in;
   status_type           pending_err_ff,   pending_err_in;
   logic [SIZE_BITS-1:0] high_water_ff,    high_water_in;

   logic                 req_fire;
   logic [7:0]           data_byte;
   logic [LEN_BITS-1:0]  payload_len;

   assign data_byte   = req_tdata[7:0];
   assign payload_len = req_tdata[8 +: LEN_BITS];

   // decode scratch
   logic                 emit;
   logic [7:0]           emit_value;
   logic [7:0]           emit_reps;
   logic [32:0]          hdr_top;        // offset + count, no wrap
   logic [LEN_BITS-1:0]  data_len;
   logic [31:0]          count_left;
   logic [31:0]          addr_sum;
   logic                 last_byte;
   logic [32:0]          final_top;
   status_type           done_status;
   rsp_item_type         rsp_new;

   always_comb begin
      byte_index_in   = byte_index_ff;
      hdr_offset_in   = hdr_offset_ff;
      hdr_count_in    = hdr_count_ff;
      rle_mode_in     = rle_mode_ff;
      phase_in        = phase_ff;
      run_token_in    = run_token_ff;
      literal_left_in = literal_left_ff;
      dest_pos_in     = dest_pos_ff;
      pending_err_in  = pending_err_ff;
      high_water_in   = high_water_ff;
      emit            = 1'b0;
      emit_value      = data_byte;
      emit_reps       = 8'd1;
      done_status     = ST_OK;

      hdr_top    = {1'b0, hdr_offset_ff} + {1'b0, hdr_count_ff};
      data_len   = payload_len - HDR_BYTES;
      count_left = hdr_count_ff - 32'(dest_pos_ff);
      addr_sum   = hdr_offset_ff + 32'(dest_pos_ff);

      unique case (phase_ff)
         PH_HEADER: begin
            // header bytes land in zeroed registers, so OR-in acts as a load
            priority if (byte_index_ff < LEN_BITS'(4)) begin
               hdr_offset_in = hdr_offset_ff |
                               (32'(data_byte) << {byte_index_ff[1:0], 3'b000});
            end else if (byte_index_ff < LEN_BITS'(8)) begin
               hdr_count_in = hdr_count_ff |
                              (32'(data_byte) << {byte_index_ff[1:0], 3'b000});
            end else begin
               rle_mode_in = (data_byte != 8'h00);
               dest_pos_in = '0;
               priority if (payload_len < HDR_BYTES || !vram_ready_ff)
                  pending_err_in = ST_INVALID;
               else if (hdr_top > 33'(vram_size_ff))
                  pending_err_in = ST_FULL;
               else if (!rle_mode_in && 32'(data_len) < hdr_count_ff)
                  pending_err_in = ST_INVALID;
               else
                  pending_err_in = pending_err_ff;
               if (pending_err_in != ST_OK)  phase_in = PH_IGNORE;
               else if (rle_mode_in)        phase_in = PH_TOKEN;
               else                         phase_in = PH_RAW;
            end
         end
         PH_RAW: begin
            if (32'(dest_pos_ff) < hdr_count_ff) emit = 1'b1;
         end
         PH_TOKEN: begin
            priority if (32'(dest_pos_ff) >= hdr_count_ff) begin
               phase_in = PH_IGNORE;
            end else if (data_byte == LITERAL_TOKEN) begin
               phase_in = PH_LITLEN;
            end else begin
               run_token_in = data_byte;
               phase_in     = PH_VALUE;
            end
         end
         PH_VALUE: begin
            // run clipped to what is left of count
            emit      = 1'b1;
            emit_reps = (32'(run_token_ff) < count_left) ? run_token_ff
                                                         : count_left[7:0];
            phase_in  = PH_TOKEN;
         end
         PH_LITLEN: begin
            literal_left_in = data_byte;
            phase_in        = (data_byte != 8'h00) ? PH_LITERAL : PH_TOKEN;
         end
         PH_LITERAL: begin
            if (32'(dest_pos_ff) >= hdr_count_ff) begin
               phase_in = PH_IGNORE;
            end else begin
               emit            = 1'b1;
               literal_left_in = literal_left_ff - 8'd1;
               if (literal_left_in == 8'd0) phase_in = PH_TOKEN;
            end
         end
         default: ;   // PH_IGNORE and unused codes: swallow the byte
      endcase

      if (emit) dest_pos_in = dest_pos_ff + SIZE_BITS'(emit_reps);

      last_byte = ({1'b0, byte_index_ff} + 1'b1) >= {1'b0, payload_len};
      final_top = {1'b0, hdr_offset_in} + {1'b0, hdr_count_in};

      if (last_byte) begin
         priority if (pending_err_in != ST_OK) begin
            done_status = pending_err_in;
         end else if (phase_in == PH_HEADER) begin
            done_status = ST_INVALID;     // packet shorter than header
         end else if (rle_mode_in && 32'(dest_pos_in) < hdr_count_in) begin
            done_status = ST_INVALID;     // RLE stream ran dry
         end else begin
            done_status = ST_OK;
            if (final_top > 33'(high_water_ff))
               high_water_in = final_top[SIZE_BITS-1:0];
         end
         byte_index_in   = '0;
         hdr_offset_in   = '0;
         hdr_count_in    = '0;
         rle_mode_in     = 1'b0;
         phase_in        = PH_HEADER;
         run_token_in    = '0;
         literal_left_in = '0;
         dest_pos_in     = '0;
         pending_err_in  = ST_OK;
      end else begin
         byte_index_in = byte_index_ff + 1'b1;
      end

      rsp_new.last                 = last_byte;
      rsp_new.fields.write_valid   = emit;
      rsp_new.fields.write_address = emit ? addr_sum[VRAM_ADDR_BITS-1:0] : '0;
      rsp_new.fields.write_value   = emit ? emit_value : 8'h00;
      rsp_new.fields.write_repeat  = emit ? emit_reps : 8'h00;
      rsp_new.fields.status        = done_status;
      rsp_new.fields.used_bytes    = high_water_in;
      rsp_new.fields.free_bytes    = (vram_size_ff > high_water_in) ?
                                     (vram_size_ff - high_water_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= '0;
         hdr_offset_ff   <= '0;
         hdr_count_ff    <= '0;
         rle_mode_ff     <= 1'b0;
         phase_ff        <= PH_HEADER;
         run_token_ff    <= '0;
         literal_left_ff <= '0;
         dest_pos_ff     <= '0;
         pending_err_ff  <= ST_OK;
         high_water_ff   <= '0;
      end else if (req_fire) begin
         byte_index_ff   <= byte_index_in;
         hdr_offset_ff   <= hdr_offset_in;
         hdr_count_ff    <= hdr_count_in;
         rle_mode_ff     <= rle_mode_in;
         phase_ff        <= phase_in;
         run_token_ff    <= run_token_in;
         literal_left_ff <= literal_left_in;
         dest_pos_ff     <= dest_pos_in;
         pending_err_ff  <= pending_err_in;
         high_water_ff   <= high_water_in;
      end
   end

   // ---------------- result buffer: main register + skid entry ----------------
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   logic         rsp_pop;

   assign req_tready = ~skid_valid_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_pop    = main_valid_ff & rsp_tready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // input is stalled here; drain skid into main once main moves
         if (rsp_pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         if (req_fire) begin
            if (!main_valid_ff || rsp_pop) begin
               main_in       = rsp_new;
               main_valid_in = 1'b1;
            end else begin
               skid_in       = rsp_new;
               skid_valid_in = 1'b1;
            end
         end else if (rsp_pop) begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tlast  = main_ff.last;
   assign rsp_tdata  = RSP_DATA_W'(main_ff.fields);

endmodule

@@ hw/rtl/vurw_checker.sv @@
// Port-level checker for the upload RLE writer, bound to the writer core
`include "vram_upload_rle_writer_core_assert.svh"

module vurw_checker import vurw_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic                  rsp_write;
   logic [7:0]            rsp_repeat;
   logic [1:0]            rsp_status;

   assign rsp_write  = rsp_tdata[0];
   assign rsp_repeat = rsp_tdata[RSP_REPEAT_LSB +: 8];
   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: 2];

   // a stalled result holds still
   `VURW_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // status only means something on the packet's last byte
   `VURW_ASSERT_IMP(a_status_last, clock, reset, rsp_tvalid && !rsp_tlast,
      rsp_status == ST_OK)

   // a burst always writes at least one byte, and no burst means no length
   `VURW_ASSERT_IMP(a_burst_len, clock, reset, rsp_tvalid,
      rsp_write == (rsp_repeat != 8'h00))

   // input backpressure only appears after a result was held back
   `VURW_ASSERT_IMP(a_bp_cause, clock, reset, $fell(req_tready),
      $past(rsp_tvalid) && !$past(rsp_tready))

endmodule

bind vram_upload_rle_writer_core vurw_checker u_vurw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
